// File: design/lfc_pkg.sv
// Package with shared types, constants and command codes of the frame cache.
package lfc_pkg;
  localparam int ENTRIES = 16;
  localparam int IW = $clog2(ENTRIES);
  localparam int RW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 2);
  localparam logic [CW-1:0] MAXR = CW'(ENTRIES + 1);
  localparam logic [39:0] BUDGET_RESET = 40'd268435456;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_EVICT_CLIP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_NOTICE = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_ACT,
    ST_AGE,
    ST_NEWSLOT,
    ST_FIT,
    ST_LRU,
    ST_REMOVE,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] clip;
    logic [31:0] frame;
    logic [15:0] handle;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [15:0] clip_id;
    logic [31:0] frame_number;
    logic [15:0] frame_handle;
    logic [31:0] frame_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic hit;
    logic [15:0] out_handle;
    logic [15:0] out_clip;
    logic [31:0] out_frame;
    logic [39:0] bytes_in_use;
    logic last;
  } out_item_t;
endpackage

// File: design/lfc_if.sv
// Valid/ready channel interfaces for command and result beats.
interface lfc_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [15:0] clip_id;
  logic [31:0] frame_number;
  logic [15:0] frame_handle;
  logic [31:0] frame_size;
  modport source (output valid, cmd, clip_id, frame_number, frame_handle, frame_size,
                  input ready);
  modport sink (input valid, cmd, clip_id, frame_number, frame_handle, frame_size,
                output ready);
endinterface

interface lfc_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic hit;
  logic [15:0] out_handle;
  logic [15:0] out_clip;
  logic [31:0] out_frame;
  logic [39:0] bytes_in_use;
  logic last;
  modport source (output valid, kind, hit, out_handle, out_clip, out_frame, bytes_in_use,
                  last, input ready);
  modport sink (input valid, kind, hit, out_handle, out_clip, out_frame, bytes_in_use,
                last, output ready);
endinterface

// File: design/lru_frame_cache_byte_budget.sv
// Top level of the LRU frame cache with a byte budget.
// Timing: the key scan reads one slot per cycle and stops at the first match; a lookup answer
// is queued when the scan ends, and a hit then passes through the age step to make the entry
// most recent. An insert queues its done beat after its scan, slot write and any evictions.
// Throughput: one command at a time, taken in idle; a stalled result beat holds the FSM.
// Reset: rst clears valid bits, bytes in use, FSM and output stage; budget is 268435456.
module lru_frame_cache_byte_budget (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [39:0] cfg_wdata,
  lfc_in_if.sink in_ch,
  lfc_out_if.source out_ch
);
  localparam int IW = lfc_pkg::IW;
  localparam int RW = lfc_pkg::RW;
  localparam int CW = lfc_pkg::CW;
  localparam int N = lfc_pkg::ENTRIES;

  // Valid bits and age ranks are small per-entry flip-flops that are updated in
  // parallel; the wide key, handle and size fields live in the entry memory.
  logic [N-1:0] valid;
  logic [RW-1:0] rank [N];
  logic [39:0] budget;
  logic [39:0] used;

  lfc_pkg::state_t state, state_next;
  lfc_pkg::in_item_t cur;
  logic [IW:0] idx;          // scan counter, one wider to hold N
  logic found;
  logic [IW-1:0] slot;       // slot chosen by the current scan
  logic [CW-1:0] nres;       // notice beats emitted for this command
  logic [IW-1:0] lru_s;
  logic lru_ok;
  lfc_pkg::out_item_t obeat;
  logic push;
  logic ofull;
  logic after_remove_insert; // room is made, or the entry of this insert is in place

  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  lfc_pkg::entry_t ram_wdata, ram_rdata;

  lfc_entry_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  lfc_out_reg u_out (
    .clk(clk), .rst(rst), .push(push), .item(obeat), .full(ofull), .o(out_ch)
  );

  wire ofree = !ofull || out_ch.ready;
  assign in_ch.ready = (state == lfc_pkg::ST_IDLE);
  wire take = in_ch.valid && in_ch.ready;
  wire [IW-1:0] ix = idx[IW-1:0];
  wire match_key = (ram_rdata.clip == cur.clip_id) && (ram_rdata.frame == cur.frame_number);

  // State register, valid bits, bytes in use and the budget register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfc_pkg::ST_IDLE;
      valid <= '0;
      used <= '0;
      budget <= lfc_pkg::BUDGET_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        budget <= cfg_wdata;
      end
      unique case (state)
        lfc_pkg::ST_ACT: begin
          if (lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_INSERT && found) begin
            used <= used - 40'(ram_rdata.size) + 40'(cur.frame_size);
          end
        end
        lfc_pkg::ST_NEWSLOT: begin
          valid[slot] <= 1'b1;
          used <= used + 40'(cur.frame_size);
        end
        lfc_pkg::ST_EMIT: begin
          if (ofree) begin
            valid[slot] <= 1'b0;
            used <= used - 40'(ram_rdata.size);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Rank updates: touch (hit or replace), age all (new entry), close gap (remove).
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      unique case (state)
        lfc_pkg::ST_AGE: begin
          if (found) begin
            if (valid[i] && IW'(i) != slot && rank[i] < rank[slot]) begin
              rank[i] <= rank[i] + 1'b1;
            end
            if (IW'(i) == slot) begin
              rank[i] <= '0;
            end
          end
        end
        lfc_pkg::ST_NEWSLOT: begin
          if (valid[i]) begin
            rank[i] <= rank[i] + 1'b1;
          end
          if (IW'(i) == slot) begin
            rank[i] <= '0;
          end
        end
        lfc_pkg::ST_EMIT: begin
          if (ofree && valid[i] && rank[i] > rank[slot]) begin
            rank[i] <= rank[i] - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= lfc_pkg::in_item_t'({in_ch.cmd, in_ch.clip_id, in_ch.frame_number,
                                  in_ch.frame_handle, in_ch.frame_size});
      nres <= '0;
      after_remove_insert <= 1'b0;
    end
    unique case (state)
      lfc_pkg::ST_IDLE: begin
        idx <= '0;
        found <= 1'b0;
      end
      lfc_pkg::ST_RD: begin
        // Read data of slot ix is now registered.
        if (!found && valid[ix]) begin
          if (lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_EVICT_CLIP) begin
            if (ram_rdata.clip == cur.clip_id) begin
              found <= 1'b1;
              slot <= ix;
            end
          end else if (match_key) begin
            found <= 1'b1;
            slot <= ix;
          end
        end
        if (found || idx == (IW+1)'(N-1)) begin
          idx <= idx;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      lfc_pkg::ST_ACT: begin
        if (lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_INSERT && !found) begin
          // Lowest free slot, if any.
          lru_ok <= ~&valid;
          for (int i = N - 1; i >= 0; i--) begin
            if (!valid[i]) begin
              slot <= IW'(i);
            end
          end
        end
      end
      lfc_pkg::ST_AGE: begin
        after_remove_insert <= 1'b1;
      end
      lfc_pkg::ST_NEWSLOT: begin
        after_remove_insert <= 1'b1;
      end
      lfc_pkg::ST_FIT: begin
        idx <= '0;
        lru_ok <= 1'b0;
      end
      lfc_pkg::ST_LRU: begin
        if (valid[ix] && (!lru_ok || rank[ix] > rank[lru_s])) begin
          lru_s <= ix;
          lru_ok <= 1'b1;
        end
        idx <= idx + 1'b1;
      end
      lfc_pkg::ST_EMIT: begin
        if (ofree) begin
          nres <= nres + 1'b1;
          if (lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_INSERT && !found) begin
            after_remove_insert <= 1'b1;
          end
          idx <= (lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_EVICT_CLIP) ?
                 (IW+1)'(slot) + 1'b1 : idx;
          found <= 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (state == lfc_pkg::ST_LRU && idx == (IW+1)'(N)) begin
      slot <= lru_s;
    end
  end

  // Next state, memory port controls and the result beat.
  always_comb begin
    state_next = state;
    push = 1'b0;
    obeat = '0;
    obeat.bytes_in_use = used;
    ram_we = 1'b0;
    ram_waddr = slot;
    ram_wdata = '{clip: cur.clip_id, frame: cur.frame_number,
                  handle: cur.frame_handle, size: cur.frame_size};
    ram_raddr = ix;
    unique case (state)
      lfc_pkg::ST_IDLE: begin
        if (take) begin
          if ((in_ch.cmd == lfc_pkg::CMD_INSERT && in_ch.frame_handle == '0) ||
              in_ch.cmd == lfc_pkg::CMD_NONE) begin
            state_next = lfc_pkg::ST_DONE;
          end else begin
            state_next = lfc_pkg::ST_SCAN;
          end
        end
      end
      lfc_pkg::ST_SCAN: begin
        ram_raddr = ix;
        state_next = lfc_pkg::ST_RD;
      end
      lfc_pkg::ST_RD: begin
        // The clip walk and the key search stop at the first match.
        priority if (!found && valid[ix] &&
                     ((lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_EVICT_CLIP) ?
                      (ram_rdata.clip == cur.clip_id) : match_key)) begin
          ram_raddr = ix;
          state_next = lfc_pkg::ST_ACT;
        end else if (idx == (IW+1)'(N-1)) begin
          ram_raddr = ix;
          state_next = lfc_pkg::ST_ACT;
        end else begin
          ram_raddr = IW'(idx + 1'b1);
          state_next = lfc_pkg::ST_RD;
        end
      end
      lfc_pkg::ST_ACT: begin
        ram_raddr = slot;
        unique case (lfc_pkg::cmd_t'(cur.cmd))
          lfc_pkg::CMD_LOOKUP: begin
            if (ofree) begin
              push = 1'b1;
              obeat.kind = lfc_pkg::KIND_LOOKUP;
              obeat.hit = found;
              obeat.out_handle = found ? ram_rdata.handle : '0;
              obeat.last = 1'b1;
              state_next = found ? lfc_pkg::ST_AGE : lfc_pkg::ST_IDLE;
            end
          end
          lfc_pkg::CMD_INSERT: begin
            if (found) begin
              ram_we = 1'b1;
              ram_waddr = slot;
              ram_wdata.clip = ram_rdata.clip;
              ram_wdata.frame = ram_rdata.frame;
              state_next = lfc_pkg::ST_AGE;
            end else begin
              state_next = (&valid) ? lfc_pkg::ST_FIT : lfc_pkg::ST_NEWSLOT;
            end
          end
          lfc_pkg::CMD_EVICT_CLIP: begin
            state_next = found ? lfc_pkg::ST_REMOVE : lfc_pkg::ST_DONE;
          end
          default: begin
            state_next = lfc_pkg::ST_DONE;
          end
        endcase
      end
      lfc_pkg::ST_AGE: begin
        state_next = (lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_LOOKUP) ?
                     lfc_pkg::ST_IDLE : lfc_pkg::ST_FIT;
      end
      lfc_pkg::ST_NEWSLOT: begin
        ram_we = 1'b1;
        ram_waddr = slot;
        state_next = lfc_pkg::ST_FIT;
      end
      lfc_pkg::ST_FIT: begin
        // A full table on a new key evicts once before the new entry goes in.
        if (lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_INSERT && !found &&
            !after_remove_insert && &valid) begin
          state_next = lfc_pkg::ST_LRU;
        end else if (used > budget && |valid) begin
          state_next = lfc_pkg::ST_LRU;
        end else begin
          state_next = lfc_pkg::ST_DONE;
        end
      end
      lfc_pkg::ST_LRU: begin
        if (idx == (IW+1)'(N)) begin
          state_next = lfc_pkg::ST_REMOVE;
        end
      end
      lfc_pkg::ST_REMOVE: begin
        ram_raddr = slot;
        state_next = lfc_pkg::ST_EMIT;
      end
      lfc_pkg::ST_EMIT: begin
        ram_raddr = slot;
        if (ofree) begin
          push = 1'b1;
          obeat.kind = lfc_pkg::KIND_NOTICE;
          obeat.out_handle = ram_rdata.handle;
          obeat.out_clip = ram_rdata.clip;
          obeat.out_frame = ram_rdata.frame;
          obeat.bytes_in_use = used - 40'(ram_rdata.size);
          obeat.last = (nres + 1'b1 == lfc_pkg::MAXR);
          if (obeat.last) begin
            state_next = lfc_pkg::ST_IDLE;
          end else if (lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_EVICT_CLIP) begin
            state_next = (slot == IW'(N - 1)) ? lfc_pkg::ST_DONE : lfc_pkg::ST_SCAN;
          end else if (!found && !after_remove_insert &&
                       lfc_pkg::cmd_t'(cur.cmd) == lfc_pkg::CMD_INSERT) begin
            state_next = lfc_pkg::ST_NEWSLOT;
          end else begin
            state_next = lfc_pkg::ST_FIT;
          end
        end
      end
      lfc_pkg::ST_DONE: begin
        if (ofree) begin
          push = 1'b1;
          obeat.kind = lfc_pkg::KIND_DONE;
          obeat.last = 1'b1;
          state_next = lfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lfc_pkg::ST_IDLE;
      end
    endcase
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != lfc_pkg::ST_IDLE) |-> !in_ch.ready) else $error("busy but ready");
  a_result_count: assert property (@(posedge clk) disable iff (rst)
    push |-> (nres < lfc_pkg::MAXR)) else $error("too many results");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (push && obeat.last) |=> (state == lfc_pkg::ST_IDLE || state == lfc_pkg::ST_AGE))
    else $error("last not final");
endmodule

// File: design/lfc_entry_ram.sv
// Entry memory: one write port and one registered read port.
module lfc_entry_ram (
  input  logic clk,
  input  logic we,
  input  logic [lfc_pkg::IW-1:0] waddr,
  input  lfc_pkg::entry_t wdata,
  input  logic [lfc_pkg::IW-1:0] raddr,
  output lfc_pkg::entry_t rdata
);
  lfc_pkg::entry_t mem [lfc_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/lfc_out_reg.sv
// Output register stage holding one result beat until it is taken.
module lfc_out_reg (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  lfc_pkg::out_item_t item,
  output logic full,
  lfc_out_if.source o
);
  lfc_pkg::out_item_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (o.ready) begin
      full <= 1'b0;
    end
    if (push) begin
      held <= item;
    end
  end

  assign o.valid = full;
  assign o.kind = held.kind;
  assign o.hit = held.hit;
  assign o.out_handle = held.out_handle;
  assign o.out_clip = held.out_clip;
  assign o.out_frame = held.out_frame;
  assign o.bytes_in_use = held.bytes_in_use;
  assign o.last = held.last;

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || o.ready)) else $error("result pushed over held beat");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (full && !o.ready) |=> full) else $error("held beat lost");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (full && !o.ready && !push) |=> $stable(held)) else $error("held beat changed");
endmodule

// File: bench/lru_frame_cache_byte_budget_test.sv
// Self-checking bench for the LRU frame cache with a byte budget.
`timescale 1ns / 1ps

module lru_frame_cache_byte_budget_test;

  // The slowest command is a full-table insert under a zero budget. It gives
  // seventeen notices, each one walking all the slots, and each notice may
  // wait out a long stall on the result side. This limit is well above that.
  localparam int STALL_LIMIT = 20000;
  // A lookup scans at most the whole entry memory, so this many quiet cycles is
  // enough for the block to settle after the last expected beat.
  localparam int SETTLE_CYCLES = 4 * lfc_pkg::ENTRIES + 8;

  logic clk = 1'b1;
  logic rst;
  logic cfg_we;
  logic [39:0] cfg_wdata;

  lfc_in_if in_ch (clk);
  lfc_out_if out_ch (clk);

  lru_frame_cache_byte_budget DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b0;
    #4 clk = 1'b1;
  end

  // Shadow copy of the cache contents, kept in step with every accepted
  // command beat.
  logic slot_used [lfc_pkg::ENTRIES];
  logic [15:0] slot_clip [lfc_pkg::ENTRIES];
  logic [31:0] slot_frame [lfc_pkg::ENTRIES];
  logic [15:0] slot_handle [lfc_pkg::ENTRIES];
  logic [31:0] slot_size [lfc_pkg::ENTRIES];
  int slot_age [lfc_pkg::ENTRIES];
  logic [39:0] held_bytes;
  logic [39:0] byte_budget;

  // Result beats still owed by the block, oldest first.
  lfc_pkg::out_item_t owed_beats[$];
  int beats_this_cmd;

  int mismatches = 0;
  int cmds_sent = 0;
  int beats_seen = 0;
  int notices_seen = 0;
  int hits_seen = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  // Result beats of one command are capped at ENTRIES + 1; anything past
  // the cap is dropped.
  function automatic void owe_beat(logic [1:0] kind, logic hit, logic [15:0] handle,
                                   logic [15:0] clip, logic [31:0] frame, logic last);
    lfc_pkg::out_item_t beat;
    if (beats_this_cmd < int'(lfc_pkg::MAXR)) begin
      beat.kind = kind;
      beat.hit = hit;
      beat.out_handle = handle;
      beat.out_clip = clip;
      beat.out_frame = frame;
      beat.bytes_in_use = held_bytes;
      beat.last = last;
      owed_beats.push_back(beat);
      beats_this_cmd++;
    end
  endfunction

  // Close a command with a done beat, or, when the notices already hit the
  // cap, mark the final notice as last instead.
  function automatic void close_command();
    if (beats_this_cmd < int'(lfc_pkg::MAXR)) begin
      owe_beat(lfc_pkg::KIND_DONE, 1'b0, 16'd0, 16'd0, 32'd0, 1'b1);
    end else begin
      owed_beats[owed_beats.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic int find_slot(logic [15:0] clip, logic [31:0] frame);
    for (int i = 0; i < lfc_pkg::ENTRIES; i++)
      if (slot_used[i] && slot_clip[i] == clip && slot_frame[i] == frame) return i;
    return -1;
  endfunction

  // Make one slot the most recent; everything younger ages by one.
  function automatic void make_recent(int s);
    int r;
    r = slot_age[s];
    for (int i = 0; i < lfc_pkg::ENTRIES; i++)
      if (slot_used[i] && i != s && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic void drop_slot(int s);
    slot_used[s] = 1'b0;
    for (int i = 0; i < lfc_pkg::ENTRIES; i++)
      if (slot_used[i] && slot_age[i] > slot_age[s]) slot_age[i]--;
    held_bytes = held_bytes - 40'(slot_size[s]);
    owe_beat(lfc_pkg::KIND_NOTICE, 1'b0, slot_handle[s], slot_clip[s], slot_frame[s], 1'b0);
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < lfc_pkg::ENTRIES; i++)
      if (slot_used[i] && (best < 0 || slot_age[i] > slot_age[best])) best = i;
    return best;
  endfunction

  function automatic void store_frame(logic [15:0] clip, logic [31:0] frame,
                                      logic [15:0] handle, logic [31:0] size);
    int s;
    s = find_slot(clip, frame);
    if (s >= 0) begin
      make_recent(s);
      held_bytes = held_bytes - 40'(slot_size[s]) + 40'(size);
      slot_handle[s] = handle;
      slot_size[s] = size;
    end else begin
      for (int i = 0; i < lfc_pkg::ENTRIES && s < 0; i++)
        if (!slot_used[i]) s = i;
      // A full table gives up its oldest entry to make room.
      if (s < 0) begin
        s = oldest_slot();
        drop_slot(s);
      end
      for (int i = 0; i < lfc_pkg::ENTRIES; i++)
        if (slot_used[i]) slot_age[i]++;
      slot_used[s] = 1'b1;
      slot_clip[s] = clip;
      slot_frame[s] = frame;
      slot_handle[s] = handle;
      slot_size[s] = size;
      slot_age[s] = 0;
      held_bytes = held_bytes + 40'(size);
    end
    // Trim to the budget, oldest first; an oversized frame goes last.
    while (held_bytes > byte_budget && oldest_slot() >= 0) drop_slot(oldest_slot());
  endfunction

  // Work out every result beat that one accepted command beat causes.
  function automatic void predict_command(logic [1:0] cmd, logic [15:0] clip,
                                          logic [31:0] frame, logic [15:0] handle,
                                          logic [31:0] size);
    int s;
    beats_this_cmd = 0;
    case (cmd)
      lfc_pkg::CMD_LOOKUP: begin
        s = find_slot(clip, frame);
        if (s >= 0) begin
          make_recent(s);
          owe_beat(lfc_pkg::KIND_LOOKUP, 1'b1, slot_handle[s], 16'd0, 32'd0, 1'b1);
        end else begin
          owe_beat(lfc_pkg::KIND_LOOKUP, 1'b0, 16'd0, 16'd0, 32'd0, 1'b1);
        end
      end
      lfc_pkg::CMD_INSERT: begin
        // A null handle leaves the cache alone.
        if (handle != 16'd0) store_frame(clip, frame, handle, size);
        close_command();
      end
      lfc_pkg::CMD_EVICT_CLIP: begin
        for (int i = 0; i < lfc_pkg::ENTRIES; i++)
          if (slot_used[i] && slot_clip[i] == clip) drop_slot(i);
        close_command();
      end
      default: close_command();
    endcase
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("[%0t] beat %0d: %s is 0x%0h, expected 0x%0h", $realtime, beats_seen,
             field, got, want);
  endtask

  // Drive one command beat at the falling edge and hold it until the block
  // takes it. The shadow cache is updated at acceptance.
  task automatic send_cmd(logic [1:0] cmd, logic [15:0] clip, logic [31:0] frame,
                          logic [15:0] handle, logic [31:0] size);
    int gap;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.clip_id = clip;
    in_ch.frame_number = frame;
    in_ch.frame_handle = handle;
    in_ch.frame_size = size;
    do @(posedge clk); while (!in_ch.ready);
    predict_command(cmd, clip, frame, handle, size);
    cmds_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // The budget only changes once the block has delivered everything and
  // had time to go back to idle. The command beat already taken is
  // withdrawn first so that it is not taken twice.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_budget(logic [39:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    byte_budget = value;
  endtask

  task automatic send_random(int clips, int frames, logic [31:0] size_max);
    int r;
    logic [1:0] cmd;
    logic [15:0] clip;
    logic [31:0] frame;
    logic [15:0] handle;
    logic [31:0] size;
    r = $urandom_range(0, 99);
    if (r < 48) cmd = lfc_pkg::CMD_INSERT;
    else if (r < 84) cmd = lfc_pkg::CMD_LOOKUP;
    else if (r < 96) cmd = lfc_pkg::CMD_EVICT_CLIP;
    else cmd = lfc_pkg::CMD_NONE;
    // A small key pool keeps hits, replacements and clip sweeps frequent;
    // the odd full-range key exercises the upper bits.
    clip = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, clips - 1));
    frame = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, frames - 1));
    handle = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    size = ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(0, size_max);
    send_cmd(cmd, clip, frame, handle, size);
  endtask

  // Lookups into an empty cache, the unused command, a null insert and a clip
  // sweep, all at the extremes of the key fields.
  task automatic test_empty_cache();
    send_cmd(lfc_pkg::CMD_LOOKUP, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    send_cmd(lfc_pkg::CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(lfc_pkg::CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(lfc_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0100);
    send_cmd(lfc_pkg::CMD_EVICT_CLIP, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000);
  endtask

  // Insert, hit, replace and clip sweep under the reset budget.
  task automatic test_hit_replace_sweep();
    send_cmd(lfc_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_1000);
    send_cmd(lfc_pkg::CMD_INSERT, 16'h0001, 32'h0000_0000, 16'h0001, 32'h0000_0000);
    send_cmd(lfc_pkg::CMD_INSERT, 16'h0001, 32'h0000_0005, 16'h1234, 32'h0002_0000);
    send_cmd(lfc_pkg::CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    send_cmd(lfc_pkg::CMD_INSERT, 16'h0001, 32'h0000_0005, 16'h4321, 32'h0003_0000);
    send_cmd(lfc_pkg::CMD_LOOKUP, 16'h0001, 32'h0000_0005, 16'h0000, 32'h0000_0000);
    send_cmd(lfc_pkg::CMD_EVICT_CLIP, 16'h0001, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    send_cmd(lfc_pkg::CMD_LOOKUP, 16'h0001, 32'h0000_0000, 16'h0000, 32'h0000_0000);
  endtask

  // Overfill the table, then drop the budget to zero so that one insert
  // evicts everything and the notices alone use up the beat cap. Finally an
  // oversized frame under a small budget evicts itself.
  task automatic test_full_table();
    set_budget(40'hFF_FFFF_FFFF);
    for (int i = 0; i < lfc_pkg::ENTRIES + 1; i++)
      send_cmd(lfc_pkg::CMD_INSERT, 16'h0002, 32'(i), 16'(i + 16'h100), 32'hFFFF_FFFF);
    set_budget(40'd0);
    send_cmd(lfc_pkg::CMD_INSERT, 16'h0003, 32'h0000_0000, 16'h0777, 32'h0000_0010);
    set_budget(40'd1000);
    send_cmd(lfc_pkg::CMD_INSERT, 16'h0004, 32'h0000_0001, 16'h0055, 32'h0000_0200);
    send_cmd(lfc_pkg::CMD_INSERT, 16'h0004, 32'h0000_0002, 16'h0066, 32'h0000_2000);
  endtask

  // Random traffic across several budgets, one stretch of it with no gaps.
  task automatic test_random_traffic();
    set_budget(40'd4000);
    repeat (50) send_random(4, 8, 32'd900);
    set_budget(lfc_pkg::BUDGET_RESET);
    no_gaps = 1'b1;
    repeat (30) send_random(3, 12, 32'h0100_0000);
    no_gaps = 1'b0;
    set_budget(40'hFF_FFFF_FFFF);
    repeat (50) send_random(2, 24, 32'hFFFF_FFFF);
    set_budget(40'd0);
    repeat (15) send_random(2, 4, 32'd16);
    set_budget({8'($urandom_range(0, 255)), 32'($urandom)});
    repeat (52) send_random(4, 10, 32'hFFFF_FFFF);
  endtask

  // Result side: random stalls on ready, checks at the rising edge.
  initial begin
    int hold;
    lfc_pkg::out_item_t want;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        beats_seen++;
        if (out_ch.kind == lfc_pkg::KIND_NOTICE) notices_seen++;
        if (out_ch.hit) hits_seen++;
        if (owed_beats.size() == 0) begin
          mismatches++;
          $display("[%0t] beat %0d arrived with nothing expected", $realtime, beats_seen);
        end else begin
          want = owed_beats.pop_front();
          if (out_ch.kind !== want.kind)
            report("kind", 64'(out_ch.kind), 64'(want.kind));
          if (out_ch.hit !== want.hit)
            report("hit", 64'(out_ch.hit), 64'(want.hit));
          if (out_ch.out_handle !== want.out_handle)
            report("out_handle", 64'(out_ch.out_handle), 64'(want.out_handle));
          if (out_ch.out_clip !== want.out_clip)
            report("out_clip", 64'(out_ch.out_clip), 64'(want.out_clip));
          if (out_ch.out_frame !== want.out_frame)
            report("out_frame", 64'(out_ch.out_frame), 64'(want.out_frame));
          if (out_ch.bytes_in_use !== want.bytes_in_use)
            report("bytes_in_use", 64'(out_ch.bytes_in_use), 64'(want.bytes_in_use));
          if (out_ch.last !== want.last)
            report("last", 64'(out_ch.last), 64'(want.last));
        end
      end
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        hold = pick_gap();
      end
      out_ch.ready = (hold == 0);
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d beats still expected", owed_beats.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 40'd0;
    in_ch.valid = 1'b0;
    in_ch.cmd = lfc_pkg::CMD_LOOKUP;
    in_ch.clip_id = 16'd0;
    in_ch.frame_number = 32'd0;
    in_ch.frame_handle = 16'd0;
    in_ch.frame_size = 32'd0;
    for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_age[i] = 0;
    end
    held_bytes = 40'd0;
    byte_budget = lfc_pkg::BUDGET_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_cache();
    test_hit_replace_sweep();
    test_full_table();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait_idle();

    $display("Covered %0d commands and %0d result beats (%0d eviction notices, %0d hits)",
             cmds_sent, beats_seen, notices_seen, hits_seen);
    $display("Budgets from zero to the 40-bit maximum, with %0d mismatches", mismatches);
    if (mismatches == 0 && owed_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
